/* rtl/edf_ready_queue_assert.svh */
// Assertion macros for the ready queue.
`ifndef EDF_READY_QUEUE_ASSERT_SVH
`define EDF_READY_QUEUE_ASSERT_SVH
`ifndef ASSERT_OFF
`define EDFRQ_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ready queue check failed");
`define EDFRQ_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("ready queue forbidden condition");
`else
`define EDFRQ_ASSERT(lbl, clk, rst_n, prop)
`define EDFRQ_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

/* rtl/edfrq_pkg.sv */
`timescale 1ns / 1ps
package edfrq_pkg;

    localparam int MODE_W   = 2;
    localparam int ID_W     = 4;
    localparam int NICE_W   = 8;
    localparam int TICK_W   = 47;
    localparam int DL_W     = 48;
    localparam int STAT_W   = 2;
    localparam int CNT_O_W  = 5;
    localparam int IN_W     = 72;
    localparam int OUT_W    = 16;

    // 13*nice/24 as a multiply by a rounded-up reciprocal, exact for 8-bit nice
    localparam int RECIP_SH = 16;
    localparam int RECIP_W  = 16;
    localparam int QUOT_W   = 8;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((13 * (1 << RECIP_SH) + 23) / 24);

    localparam logic [DL_W-1:0] RATIO_ADD   = 48'd10;
    localparam logic [DL_W-1:0] IDLE_OFFSET = 48'd15778463000000;

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT  = 2'd0,
        MODE_REMOVE  = 2'd1,
        MODE_FLAG    = 2'd2,
        MODE_PREEMPT = 2'd3
    } t_mode;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_DUPLICATE = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_FIND   = 2'd1,
        S_UPDATE = 2'd2,
        S_REPORT = 2'd3
    } t_state;

    typedef struct packed {
        logic [ID_W-1:0]   thread;
        logic [DL_W-1:0]   deadline;
        logic [NICE_W-1:0] nice;
        logic              running;
    } t_entry;

    typedef struct packed {
        logic              ins;
        logic              rem;
        logic              set_flag;
        logic              flag;
        logic [ID_W-1:0]   id;
        logic [ID_W-1:0]   oth_id;
        logic [DL_W-1:0]   deadline;
        logic [NICE_W-1:0] nice;
    } t_cell_op;

endpackage

/* rtl/edfrq_cell.sv */
`timescale 1ns / 1ps
module edfrq_cell #(
    parameter int IDX = 0,
    parameter int CW  = 5,
    parameter int IW  = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  edfrq_pkg::t_cell_op i_op,
    input  logic [CW-1:0]       i_count,
    input  logic [IW-1:0]       i_slot,
    input  edfrq_pkg::t_entry   i_prev,
    input  logic                i_prev_lt,
    input  edfrq_pkg::t_entry   i_next,
    output edfrq_pkg::t_entry   o_entry,
    output logic                o_valid,
    output logic                o_lt,
    output logic                o_hit,
    output logic                o_hit_oth
);
    import edfrq_pkg::*;

    localparam logic [CW-1:0] MY_POS  = CW'(IDX);
    localparam logic [IW-1:0] MY_SLOT = IW'(IDX);

    logic [ID_W-1:0]   r_thread, n_thread;
    logic [DL_W-1:0]   r_deadline, n_deadline;
    logic [NICE_W-1:0] r_nice, n_nice;
    logic              r_running, n_running;

    assign o_valid   = MY_POS < i_count;
    assign o_lt      = o_valid && (r_deadline < i_op.deadline);
    assign o_hit     = o_valid && (r_thread == i_op.id);
    assign o_hit_oth = o_valid && (r_thread == i_op.oth_id);
    assign o_entry   = '{thread: r_thread, deadline: r_deadline, nice: r_nice,
                         running: r_running};

    always_comb begin
        n_thread   = r_thread;
        n_deadline = r_deadline;
        n_nice     = r_nice;
        n_running  = r_running;
        if (i_op.ins && !o_lt) begin
            if (i_prev_lt) begin
                n_thread   = i_op.id;
                n_deadline = i_op.deadline;
                n_nice     = i_op.nice;
                n_running  = 1'b0;
            end else begin
                n_thread   = i_prev.thread;
                n_deadline = i_prev.deadline;
                n_nice     = i_prev.nice;
                n_running  = i_prev.running;
            end
        end else if (i_op.rem && (MY_SLOT >= i_slot)) begin
            n_thread   = i_next.thread;
            n_deadline = i_next.deadline;
            n_nice     = i_next.nice;
            n_running  = i_next.running;
        end else if (i_op.set_flag && o_hit) begin
            n_running  = i_op.flag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_thread   <= n_thread;
        r_deadline <= n_deadline;
        r_nice     <= n_nice;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running <= 1'b0;
        end else begin
            r_running <= n_running;
        end
    end

endmodule

/* rtl/edf_ready_queue.sv */
`timescale 1ns / 1ps
// Channel  Dir  Bus               Fields (lowest bit first)
// s        in   i_s_tdata[71:0]   mode, thread_id, other_id, nice_value, idle_thread,
//                                 now_tick, flag_value
// m        out  o_m_tdata[15:0]   status, next_id, next_valid, preempt, entry_count
//
// Each word passes in turn through capture, id match, cell update and result load.
// One word is in the cell row at a time; the FSM takes no new word until its result is loaded.
// The result sits in an output register, so the next word is taken while it waits.
// A stalled master holds the FSM in its load state until the register frees.
// Synchronous active-low reset empties the table and clears running flags.
`include "edf_ready_queue_assert.svh"
module edf_ready_queue #(
    parameter int MAX_THREADS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    // mode, thread_id, other_id, nice_value, idle_thread, now_tick, flag_value
    input  logic [edfrq_pkg::IN_W-1:0] i_s_tdata,
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    // status, next_id, next_valid, preempt, entry_count
    output logic [edfrq_pkg::OUT_W-1:0] o_m_tdata
);
    import edfrq_pkg::*;

    localparam int CW = $clog2(MAX_THREADS + 1);
    localparam int IW = $clog2(MAX_THREADS);
    localparam logic [CW-1:0] FULL_CNT = CW'(MAX_THREADS);

    t_state            r_state, n_state;
    t_mode             r_mode;
    logic [ID_W-1:0]   r_id, r_oth;
    logic [NICE_W-1:0] r_nice;
    logic              r_idle, r_flag;
    logic [TICK_W-1:0] r_tick;
    logic [QUOT_W-1:0] r_quot;
    logic [DL_W-1:0]   r_deadline;
    logic [MAX_THREADS-1:0] r_hit_vec, r_oth_vec;
    logic              r_found, r_oth_found;
    logic [IW-1:0]     r_slot;
    t_status           r_status;
    logic [DL_W-1:0]   r_pd_cur, r_pd_oth;
    logic [NICE_W-1:0] r_pn_cur, r_pn_oth;
    logic [CW-1:0]     r_count;
    logic              r_out_valid;
    logic [OUT_W-1:0]  r_out_data;

    logic in_ready, ld_find, ld_update, ld_report, out_free;

    logic [NICE_W+RECIP_W-1:0] w_prod;
    t_cell_op          w_op;
    t_entry            w_entry [MAX_THREADS];
    logic [MAX_THREADS-1:0] w_valid, w_lt, w_hit, w_hit_oth;
    logic [IW-1:0]     w_slot;
    t_status           w_status;
    logic [DL_W-1:0]   w_sel_dc, w_sel_do;
    logic [NICE_W-1:0] w_sel_nc, w_sel_no;
    logic [MAX_THREADS-1:0] w_run, w_first;
    logic [ID_W-1:0]   w_nid;
    logic              w_pre;
    logic [CW+CNT_O_W-1:0] w_cnt_ext;

    // FSM
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_s_tvalid) n_state = S_FIND;
            S_FIND:   n_state = S_UPDATE;
            S_UPDATE: n_state = S_REPORT;
            S_REPORT: if (out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        in_ready  = 1'b0;
        ld_find   = 1'b0;
        ld_update = 1'b0;
        ld_report = 1'b0;
        case (r_state)
            S_IDLE:   in_ready  = 1'b1;
            S_FIND:   ld_find   = 1'b1;
            S_UPDATE: ld_update = 1'b1;
            S_REPORT: ld_report = out_free;
            default:  in_ready  = 1'b0;
        endcase
    end

    assign out_free   = !r_out_valid || i_m_tready;
    assign o_s_tready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // capture
    assign w_prod = {{RECIP_W{1'b0}}, i_s_tdata[17:10]} * {{NICE_W{1'b0}}, RECIP};

    always_ff @(posedge i_clk) begin
        if (in_ready && i_s_tvalid) begin
            r_mode <= t_mode'(i_s_tdata[1:0]);
            r_id   <= i_s_tdata[5:2];
            r_oth  <= i_s_tdata[9:6];
            r_nice <= i_s_tdata[17:10];
            r_idle <= i_s_tdata[18];
            r_tick <= i_s_tdata[65:19];
            r_flag <= i_s_tdata[66];
            r_quot <= w_prod[RECIP_SH +: QUOT_W];
        end
    end

    // cell row
    assign w_op = '{
        ins:      ld_update && (r_mode == MODE_INSERT) && !r_found && (r_count != FULL_CNT),
        rem:      ld_update && (r_mode == MODE_REMOVE) && r_found,
        set_flag: ld_update && (r_mode == MODE_FLAG) && r_found,
        flag:     r_flag,
        id:       r_id,
        oth_id:   r_oth,
        deadline: r_deadline,
        nice:     r_nice
    };

    genvar g;
    generate
        for (g = 0; g < MAX_THREADS; g++) begin : g_cell
            t_entry w_prev, w_next;
            logic   w_prev_lt;
            if (g == 0) begin : g_first
                assign w_prev    = '0;
                assign w_prev_lt = 1'b1;
            end else begin : g_mid
                assign w_prev    = w_entry[g-1];
                assign w_prev_lt = w_lt[g-1];
            end
            if (g == MAX_THREADS - 1) begin : g_last
                assign w_next = '0;
            end else begin : g_inner
                assign w_next = w_entry[g+1];
            end
            edfrq_cell #(
                .IDX (g),
                .CW  (CW),
                .IW  (IW)
            ) u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_op      (w_op),
                .i_count   (r_count),
                .i_slot    (r_slot),
                .i_prev    (w_prev),
                .i_prev_lt (w_prev_lt),
                .i_next    (w_next),
                .o_entry   (w_entry[g]),
                .o_valid   (w_valid[g]),
                .o_lt      (w_lt[g]),
                .o_hit     (w_hit[g]),
                .o_hit_oth (w_hit_oth[g])
            );
        end
    endgenerate

    // id match
    always_comb begin
        w_slot = '0;
        for (int i = 0; i < MAX_THREADS; i++) begin
            if (w_hit[i]) begin
                w_slot = w_slot | IW'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_find) begin
            r_deadline  <= {1'b0, r_tick} + {{(DL_W-QUOT_W){1'b0}}, r_quot} + RATIO_ADD
                           + (r_idle ? IDLE_OFFSET : '0);
            r_hit_vec   <= w_hit;
            r_oth_vec   <= w_hit_oth;
            r_found     <= |w_hit;
            r_oth_found <= |w_hit_oth;
            r_slot      <= w_slot;
        end
    end

    // update
    always_comb begin
        case (r_mode)
            MODE_INSERT:  w_status = r_found ? ST_DUPLICATE :
                                     (r_count == FULL_CNT) ? ST_FULL : ST_OK;
            MODE_REMOVE:  w_status = r_found ? ST_OK : ST_NOT_FOUND;
            MODE_FLAG:    w_status = r_found ? ST_OK : ST_NOT_FOUND;
            MODE_PREEMPT: w_status = (r_found && r_oth_found) ? ST_OK : ST_NOT_FOUND;
            default:      w_status = ST_OK;
        endcase
    end

    always_comb begin
        w_sel_dc = '0;
        w_sel_do = '0;
        w_sel_nc = '0;
        w_sel_no = '0;
        for (int i = 0; i < MAX_THREADS; i++) begin
            if (r_hit_vec[i]) begin
                w_sel_dc = w_sel_dc | w_entry[i].deadline;
                w_sel_nc = w_sel_nc | w_entry[i].nice;
            end
            if (r_oth_vec[i]) begin
                w_sel_do = w_sel_do | w_entry[i].deadline;
                w_sel_no = w_sel_no | w_entry[i].nice;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_update) begin
            r_status <= w_status;
            r_pd_cur <= w_sel_dc;
            r_pd_oth <= w_sel_do;
            r_pn_cur <= w_sel_nc;
            r_pn_oth <= w_sel_no;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_op.ins) begin
            r_count <= r_count + 1'b1;
        end else if (w_op.rem) begin
            r_count <= r_count - 1'b1;
        end
    end

    // report
    always_comb begin
        for (int i = 0; i < MAX_THREADS; i++) begin
            w_run[i] = w_valid[i] && w_entry[i].running;
        end
    end

    assign w_first = w_run & (~w_run + 1'b1);

    always_comb begin
        w_nid = '0;
        for (int i = 0; i < MAX_THREADS; i++) begin
            if (w_first[i]) begin
                w_nid = w_nid | w_entry[i].thread;
            end
        end
    end

    assign w_pre = (r_mode == MODE_PREEMPT) && (r_status == ST_OK)
                   && ((r_pd_oth < r_pd_cur)
                       || ((r_pd_oth == r_pd_cur) && (r_pn_oth < r_pn_cur)));

    assign w_cnt_ext = {{CNT_O_W{1'b0}}, r_count};

    always_ff @(posedge i_clk) begin
        if (ld_report) begin
            r_out_data <= {3'b000, w_cnt_ext[CNT_O_W-1:0], w_pre, |w_run, w_nid,
                           r_status};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ld_report) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    `EDFRQ_NEVER(a_count_range, i_clk, i_rst_n, r_count > FULL_CNT)
    `EDFRQ_ASSERT(a_unique_id, i_clk, i_rst_n, ld_update |-> $onehot0(r_hit_vec))
    `EDFRQ_NEVER(a_sorted_row, i_clk, i_rst_n, ((w_lt >> 1) & ~w_lt) != '0)
    `EDFRQ_ASSERT(a_insert_count, i_clk, i_rst_n, w_op.ins |=> (r_count == $past(r_count) + 1'b1))

endmodule
